// File: hdl/laplacian_zero_crossing_edge_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Laplacian zero-crossing edge block
// Implication and next-cycle checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_ZERO_CROSSING_EDGE_MACROS_SVH
`define LAPLACIAN_ZERO_CROSSING_EDGE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LZCE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZCE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LZCE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LZCE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hdl/lzce_pkg.sv
// ----------------------------------------------------------------------------
// lzce_pkg
// Types, constants and window arithmetic for the Laplacian edge block.
// ----------------------------------------------------------------------------
package lzce_pkg;

  localparam int PIXEL_BITS      = 8;
  localparam int LAP_BITS        = 12;
  localparam int ROW_BITS        = 17;  // covers the drain rows past 65535
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 16;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_IDX_BITS    = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd480;

  localparam logic [PIXEL_BITS-1:0] EDGE_ON = 8'd255;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  flush;
  } pix_in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] edge_value;
    logic                  last_pixel;
  } res_t;

  // [row][col], row 0 oldest line, col 0 oldest column
  typedef logic [2:0][2:0][PIXEL_BITS-1:0] pix_win_t;
  typedef logic [2:0][2:0][LAP_BITS-1:0]   lap_win_t;

  // eight neighbours minus eight times the centre
  function automatic logic [LAP_BITS-1:0] window_lap(pix_win_t win);
    logic [PIXEL_BITS+2:0]   sum;
    logic signed [LAP_BITS:0] diff;
    int i;
    int j;
    sum = '0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1)) begin
          sum = sum + {3'b000, win[i][j]};
        end
      end
    end
    diff = $signed({2'b00, sum}) - $signed({2'b00, win[1][1], 3'b000});
    return diff[LAP_BITS-1:0];
  endfunction

  // mark the smaller-magnitude side of a sign change
  function automatic logic is_edge(lap_win_t win);
    logic signed [LAP_BITS:0] ctr;
    logic signed [LAP_BITS:0] neg_ctr;
    logic signed [LAP_BITS:0] nb;
    logic signed [LAP_BITS:0] neg_nb;
    logic ctr_neg;
    logic ctr_pos;
    logic nb_neg;
    logic nb_pos;
    logic hit;
    int i;
    int j;
    ctr     = $signed({win[1][1][LAP_BITS-1], win[1][1]});
    neg_ctr = -ctr;
    ctr_neg = ctr[LAP_BITS];
    ctr_pos = !ctr[LAP_BITS] && (ctr != '0);
    hit     = 1'b0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1)) begin
          nb     = $signed({win[i][j][LAP_BITS-1], win[i][j]});
          neg_nb = -nb;
          nb_neg = nb[LAP_BITS];
          nb_pos = !nb[LAP_BITS] && (nb != '0);
          if (ctr_neg && nb_pos && (nb >= neg_ctr)) begin
            hit = 1'b1;
          end
          if (ctr_pos && nb_neg && (neg_nb > ctr)) begin
            hit = 1'b1;
          end
        end
      end
    end
    return hit;
  endfunction

endpackage

// File: hdl/lzce_line_buf.sv
// ----------------------------------------------------------------------------
// lzce_line_buf
// One-write one-read line memory with registered read, write-through on a
// matching address and a fill count so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module lzce_line_buf #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [AW:0]      fill_q;
  logic [AW:0]      fill_d;
  logic             rvalid_q;

  // lines are written from column 0 upwards, so the written set is a prefix
  always_comb begin
    fill_d = fill_q;
    if ({1'b0, waddr_i} >= fill_q) begin
      fill_d = {1'b0, waddr_i} + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
      rdata_q        <= (raddr_i == waddr_i) ? wdata_i : mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rvalid_q <= 1'b0;
    end else if (we_i) begin
      fill_q   <= fill_d;
      rvalid_q <= ({1'b0, raddr_i} < fill_d);
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// File: hdl/laplacian_zero_crossing_edge.sv
// ----------------------------------------------------------------------------
// laplacian_zero_crossing_edge: 3x3 Laplacian zero-crossing edge map
// Accepted beats pass m1_q and m2_q into the output register; a pixel's edge
// value rides on the beat 2W+2 stream positions later. Throughput: 1 beat per
// cycle unless stalled, set by the line buffers reading the next column ahead.
// Reset clears control and fill counts at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "laplacian_zero_crossing_edge_macros.svh"

module laplacian_zero_crossing_edge #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  lzce_pkg::pix_in_t                     in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output lzce_pkg::res_t                        out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [lzce_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [lzce_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = (CW + 1 > lzce_pkg::WIDTH_REG_BITS) ? CW + 1 : lzce_pkg::WIDTH_REG_BITS;
  localparam int RB = lzce_pkg::ROW_BITS;
  localparam int PB = lzce_pkg::PIXEL_BITS;
  localparam int LB = lzce_pkg::LAP_BITS;

  typedef struct packed {
    logic valid;
    logic lap_en;
    logic has_res;
    logic interior;
    logic done;
  } meta_t;

  // configuration
  logic [lzce_pkg::WIDTH_REG_BITS-1:0]  width_q;
  logic [lzce_pkg::HEIGHT_REG_BITS-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lzce_pkg::WIDTH_RESET;
      height_q <= lzce_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lzce_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[lzce_pkg::WIDTH_REG_BITS-1:0];
        lzce_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[lzce_pkg::HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [WB-1:0] w_ext;
  logic [WB-1:0] w_eff;
  logic [RB-1:0] h_ext;
  logic [RB-1:0] h_eff;

  always_comb begin
    w_ext = WB'(width_q);
    w_eff = w_ext;
    if (w_ext < WB'(3)) begin
      w_eff = WB'(3);
    end else if (w_ext > WB'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end
    h_ext = RB'(height_q);
    h_eff = (h_ext < RB'(3)) ? RB'(3) : h_ext;
  end

  // ---------------------------------------------------------------- stage A
  logic          en;
  logic          accept;
  logic          in_frame;
  logic          step_a;
  logic [PB-1:0] pix_a;

  logic [CW-1:0] col_q, col_d;
  logic [RB-1:0] row_q, row_d;
  logic [WB-1:0] col_ext;
  logic [RB-1:0] ro_a;
  logic [WB-1:0] co_a;
  logic          interior_a;
  logic          done_a;
  logic          has_res_a;
  logic          lap_en_a;

  logic              skid_valid_q;
  logic              out_valid_q;
  lzce_pkg::res_t    out_q;
  lzce_pkg::res_t    skid_q;

  assign en       = !skid_valid_q;
  assign accept   = in_valid_i && en;
  assign in_frame = row_q < h_eff;
  // a flush inside the pixel part of the frame does nothing
  assign step_a   = accept && !(in_data_i.flush && in_frame);
  assign pix_a    = in_frame ? in_data_i.pixel : '0;

  always_comb begin
    col_ext = WB'(col_q);
    if (col_q >= CW'(2)) begin
      ro_a = row_q - RB'(2);
      co_a = col_ext - WB'(2);
    end else begin
      // result wraps back to the end of the line before
      ro_a = row_q - RB'(3);
      co_a = w_eff - WB'(2) + col_ext;
    end
    interior_a = (ro_a >= RB'(1)) && (ro_a < h_eff - RB'(1)) &&
                 (co_a >= WB'(1)) && (co_a < w_eff - WB'(1));
    done_a     = (ro_a > h_eff - RB'(1)) ||
                 ((ro_a == h_eff - RB'(1)) && (co_a >= w_eff - WB'(1)));
    has_res_a  = (row_q >= RB'(3)) || ((row_q == RB'(2)) && (col_q >= CW'(2)));
    lap_en_a   = in_frame && (row_q >= RB'(2)) && (col_q >= CW'(2));

    col_d = col_q;
    row_d = row_q;
    if (step_a) begin
      if (has_res_a && done_a) begin
        col_d = '0;
        row_d = '0;
      end else if (col_ext + WB'(1) >= w_eff) begin
        col_d = '0;
        row_d = row_q + RB'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // pixel line buffer: upper half two lines back, lower half one line back
  logic [2*PB-1:0]    pbuf_rdata;
  logic [PB-1:0]      pix_up;
  logic [PB-1:0]      pix_mid;
  lzce_pkg::pix_win_t pwin_q;

  assign pix_up  = pbuf_rdata[2*PB-1:PB];
  assign pix_mid = pbuf_rdata[PB-1:0];

  lzce_line_buf #(
    .WIDTH (2*PB),
    .DEPTH (MAX_WIDTH)
  ) u_pix_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (step_a),
    .waddr_i (col_q),
    .wdata_i ({pix_mid, pix_a}),
    .raddr_i (col_d),
    .rdata_o (pbuf_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (step_a) begin
      pwin_q[0][0] <= pwin_q[0][1];
      pwin_q[0][1] <= pwin_q[0][2];
      pwin_q[1][0] <= pwin_q[1][1];
      pwin_q[1][1] <= pwin_q[1][2];
      pwin_q[2][0] <= pwin_q[2][1];
      pwin_q[2][1] <= pwin_q[2][2];
      pwin_q[0][2] <= pix_up;
      pwin_q[1][2] <= pix_mid;
      pwin_q[2][2] <= pix_a;
    end
  end

  meta_t         m1_q;
  logic [CW-1:0] col1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
    end else if (en) begin
      m1_q <= '{valid: step_a, lap_en: lap_en_a, has_res: has_res_a,
                interior: interior_a, done: done_a};
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_a) begin
      col1_q <= col_q;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic               we_b;
  logic [LB-1:0]      lap_b;
  logic [2*LB-1:0]    lbuf_rdata;
  logic [LB-1:0]      lap_up;
  logic [LB-1:0]      lap_mid;
  lzce_pkg::lap_win_t lwin_q;

  assign we_b    = en && m1_q.valid;
  assign lap_b   = m1_q.lap_en ? lzce_pkg::window_lap(pwin_q) : '0;
  assign lap_up  = lbuf_rdata[2*LB-1:LB];
  assign lap_mid = lbuf_rdata[LB-1:0];

  // col_q already holds the column of the next beat, so read it ahead
  lzce_line_buf #(
    .WIDTH (2*LB),
    .DEPTH (MAX_WIDTH)
  ) u_lap_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we_b),
    .waddr_i (col1_q),
    .wdata_i ({lap_mid, lap_b}),
    .raddr_i (col_q),
    .rdata_o (lbuf_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      lwin_q[0][0] <= lwin_q[0][1];
      lwin_q[0][1] <= lwin_q[0][2];
      lwin_q[1][0] <= lwin_q[1][1];
      lwin_q[1][1] <= lwin_q[1][2];
      lwin_q[2][0] <= lwin_q[2][1];
      lwin_q[2][1] <= lwin_q[2][2];
      lwin_q[0][2] <= lap_up;
      lwin_q[1][2] <= lap_mid;
      lwin_q[2][2] <= lap_b;
    end
  end

  meta_t m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_q <= '0;
    end else if (en) begin
      m2_q <= m1_q;
    end
  end

  // ------------------------------------------------------- stage C, output
  logic           res_v;
  logic           out_taken;
  lzce_pkg::res_t res_c;

  assign res_v     = en && m2_q.valid && m2_q.has_res;
  assign out_taken = out_valid_q && !out_stall_i;

  always_comb begin
    res_c.edge_value = (m2_q.interior && lzce_pkg::is_edge(lwin_q)) ? lzce_pkg::EDGE_ON : '0;
    res_c.last_pixel = m2_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_taken) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_v) begin
      if (!out_valid_q || out_taken) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_taken) begin
        out_q <= skid_q;
      end
    end else if (res_v) begin
      if (!out_valid_q || out_taken) begin
        out_q <= res_c;
      end else begin
        skid_q <= res_c;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------- checks
  `LZCE_ASSERT_IMP(a_skid_only_when_stalled, clk_i, rst_ni, $rose(skid_valid_q), $past(out_valid_q && out_stall_i), "skid loaded without a stalled output beat")
  `LZCE_ASSERT_NXT(a_pipe_frozen, clk_i, rst_ni, skid_valid_q, $stable(m2_q), "pipeline moved while skid held a beat")
  `LZCE_ASSERT_NXT(a_frame_restart, clk_i, rst_ni, step_a && has_res_a && done_a, (col_q == '0) && (row_q == '0), "position not cleared after last pixel")

endmodule

// File: test/laplacian_zero_crossing_edge_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laplacian_zero_crossing_edge_tb
// Streams frames through the Laplacian zero-crossing edge block and checks
// every edge map beat against an in-bench model of the window pipeline.
// Covers probe frames with extreme Laplacians, random textures and sizes,
// registers changed in mid-frame, the widest lines and the largest height.
// ----------------------------------------------------------------------------
module laplacian_zero_crossing_edge_tb;

  localparam int MAX_W = 1024;

  typedef enum int {
    TEX_NOISE,
    TEX_BINARY,
    TEX_FLAT,
    TEX_SPIKES,
    TEX_PROBE_DARK,
    TEX_PROBE_BRIGHT
  } texture_e;

  // Window pipeline model plus the queue of edge map beats still owed.
  class edge_scoreboard;
    logic [lzce_pkg::WIDTH_REG_BITS-1:0]  width_reg;
    logic [lzce_pkg::HEIGHT_REG_BITS-1:0] height_reg;
    logic [7:0]         pix_line [2*MAX_W];
    logic signed [11:0] lap_line [2*MAX_W];
    logic [7:0]         pix_win [3][3];
    logic signed [11:0] lap_win [3][3];
    int unsigned        col_pos;
    int unsigned        row_pos;
    lzce_pkg::res_t     edge_q[$];
    int                 errors;
    int                 frames_done;

    function new();
      width_reg  = lzce_pkg::WIDTH_RESET;
      height_reg = lzce_pkg::HEIGHT_RESET;
      foreach (pix_line[i]) pix_line[i] = '0;
      foreach (lap_line[i]) lap_line[i] = '0;
      foreach (pix_win[i, j]) pix_win[i][j] = '0;
      foreach (lap_win[i, j]) lap_win[i][j] = '0;
      col_pos     = 0;
      row_pos     = 0;
      errors      = 0;
      frames_done = 0;
    endfunction

    function void set_reg(logic [lzce_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [lzce_pkg::CFG_DATA_BITS-1:0] val);
      if (idx == lzce_pkg::REG_IMAGE_WIDTH) begin
        width_reg = val[lzce_pkg::WIDTH_REG_BITS-1:0];
      end else begin
        height_reg = val[lzce_pkg::HEIGHT_REG_BITS-1:0];
      end
    endfunction

    function int eff_w();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int eff_h();
      if (height_reg < 3) return 3;
      return height_reg;
    endfunction

    function bit in_pixel_part();
      return row_pos < eff_h();
    endfunction

    function int pending();
      return edge_q.size();
    endfunction

    // smaller-magnitude side of a sign change
    function bit centre_is_edge();
      int ctr;
      int nb;
      ctr = lap_win[1][1];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          nb = lap_win[i][j];
          if (!(i == 1 && j == 1)) begin
            if (ctr < 0 && nb > 0 && nb >= -ctr) return 1'b1;
            if (ctr > 0 && nb < 0 && -nb > ctr) return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_beat(lzce_pkg::pix_in_t beat);
      int w;
      int h;
      int r;
      int c;
      int s;
      int lap;
      int ro;
      int co;
      logic [7:0] p;
      logic [7:0] a;
      logic [7:0] b;
      logic signed [11:0] la;
      logic signed [11:0] lb;
      bit interior;
      bit done;
      lzce_pkg::res_t res;
      w = eff_w();
      h = eff_h();
      r = row_pos;
      c = col_pos;
      if (c >= MAX_W) c = MAX_W - 1;
      // flush inside the pixel part is dropped outright
      if (beat.flush && r < h) return;
      p = (r < h) ? beat.pixel : 8'd0;

      a = pix_line[MAX_W+c];
      b = pix_line[c];
      pix_line[MAX_W+c] = b;
      pix_line[c] = p;
      for (int i = 0; i < 3; i++) begin
        pix_win[i][0] = pix_win[i][1];
        pix_win[i][1] = pix_win[i][2];
      end
      pix_win[0][2] = a;
      pix_win[1][2] = b;
      pix_win[2][2] = p;

      lap = 0;
      if (c >= 2 && r >= 2 && r - 1 <= h - 2) begin
        s = 0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            if (!(i == 1 && j == 1)) s = s + int'(pix_win[i][j]);
          end
        end
        lap = s - 8 * int'(pix_win[1][1]);
      end

      la = lap_line[MAX_W+c];
      lb = lap_line[c];
      lap_line[MAX_W+c] = lb;
      lap_line[c] = lap[11:0];
      for (int i = 0; i < 3; i++) begin
        lap_win[i][0] = lap_win[i][1];
        lap_win[i][1] = lap_win[i][2];
      end
      lap_win[0][2] = la;
      lap_win[1][2] = lb;
      lap_win[2][2] = lap[11:0];

      if (r >= 3 || (r == 2 && c >= 2)) begin
        if (c >= 2) begin
          ro = r - 2;
          co = c - 2;
        end else begin
          ro = r - 3;
          co = c + w - 2;
        end
        interior = ro >= 1 && ro <= h - 2 && co >= 1 && co <= w - 2;
        done = ro > h - 1 || (ro == h - 1 && co >= w - 1);
        res.edge_value = (interior && centre_is_edge()) ? lzce_pkg::EDGE_ON : 8'd0;
        res.last_pixel = done;
        edge_q.push_back(res);
        if (done) begin
          row_pos = 0;
          col_pos = 0;
          frames_done++;
          return;
        end
      end

      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_result(lzce_pkg::res_t got);
      lzce_pkg::res_t want;
      if (edge_q.size() == 0) begin
        $error("edge map beat with none owed: edge_value %0d last_pixel %0d",
               got.edge_value, got.last_pixel);
        errors++;
        return;
      end
      want = edge_q.pop_front();
      if (got.edge_value !== want.edge_value) begin
        $error("edge_value expected %0d actual %0d", want.edge_value, got.edge_value);
        errors++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel expected %0d actual %0d", want.last_pixel, got.last_pixel);
        errors++;
      end
    endfunction
  endclass

  logic                               clk_i     = 1'b0;
  logic                               rst_ni    = 1'b0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  lzce_pkg::pix_in_t                  in_data   = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  lzce_pkg::res_t                     out_data;
  logic                               cfg_we    = 1'b0;
  logic [lzce_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [lzce_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

  edge_scoreboard sb = new();
  int idle_pct  = 0;
  int items_sent = 0;

  laplacian_zero_crossing_edge uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("laplacian_zero_crossing_edge verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_data);
    end
  end

  // receiver back-pressure in bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] next_pixel(texture_e tex);
    case (tex)
      TEX_BINARY:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      TEX_FLAT:         return 8'($urandom_range(100, 108));
      TEX_SPIKES:       return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'd128;
      TEX_PROBE_DARK:   return (sb.row_pos == 1 && sb.col_pos == 1) ? 8'd255 : 8'd0;
      TEX_PROBE_BRIGHT: return (sb.row_pos == 1 && sb.col_pos == 1) ? 8'd0 : 8'd255;
      default:          return 8'($urandom);
    endcase
  endfunction

  // called at a clock edge; returns at the edge on which the beat is taken
  task automatic send_beat(lzce_pkg::pix_in_t beat);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    sb.note_beat(beat);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // beats in the fill phase owe nothing, so give the pipeline time to empty
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [lzce_pkg::WIDTH_REG_BITS-1:0] w,
                           logic [lzce_pkg::HEIGHT_REG_BITS-1:0] h);
    logic [lzce_pkg::CFG_DATA_BITS-1:0] wdata;
    wdata = {5'($urandom), w};  // upper bits are don't-care for the width
    cfg_we    <= 1'b1;
    cfg_index <= lzce_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= wdata;
    @(posedge clk_i);
    sb.set_reg(lzce_pkg::REG_IMAGE_WIDTH, wdata);
    cfg_index <= lzce_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk_i);
    sb.set_reg(lzce_pkg::REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cfg();
    logic [lzce_pkg::WIDTH_REG_BITS-1:0]  w;
    logic [lzce_pkg::HEIGHT_REG_BITS-1:0] h;
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) begin
      w = 11'($urandom_range(0, 2));
    end else if (pick < 4) begin
      w = 11'($urandom_range(13, 40));
    end else begin
      w = 11'($urandom_range(3, 12));
    end
    h = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom_range(3, 8));
    write_cfg(w, h);
  endtask

  // one whole frame with drain; cut_at >= 0 resizes mid-frame after that many beats
  task automatic run_frame(texture_e tex, int cut_at);
    int start_frames;
    int beats;
    bit dropped;
    lzce_pkg::pix_in_t beat;
    start_frames = sb.frames_done;
    beats = 0;
    while (sb.frames_done == start_frames) begin
      if (beats == cut_at) begin
        settle();
        random_cfg();
      end
      if (sb.in_pixel_part()) begin
        beat.flush = ($urandom_range(0, 19) == 0);
        beat.pixel = next_pixel(tex);
        dropped = beat.flush;
      end else begin
        // drain: the odd pixel beat stands in for a flush
        beat.flush = ($urandom_range(0, 5) != 0);
        beat.pixel = 8'($urandom);
        dropped = 1'b0;
      end
      send_beat(beat);
      if (!dropped) begin
        beats++;
        items_sent++;
      end
    end
  endtask

  task automatic probe_frame(texture_e tex);
    lzce_pkg::pix_in_t beat;
    for (int i = 0; i < 12; i++) begin
      beat.flush = 1'b0;
      beat.pixel = next_pixel(tex);
      send_beat(beat);
      if (i == 6) begin
        beat.flush = 1'b1;
        beat.pixel = 8'hA5;
        send_beat(beat);
      end
    end
    for (int i = 0; i < 10; i++) begin
      beat.flush = (i != 3);
      beat.pixel = 8'h5A;
      send_beat(beat);
    end
  endtask

  initial begin
    int nframes;
    int cut;
    texture_e tex;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // probes: centre at -2040 and at +2040 on a 4x3 frame
    write_cfg(11'd4, 16'd3);
    probe_frame(TEX_PROBE_DARK);
    probe_frame(TEX_PROBE_BRIGHT);
    settle();

    while (items_sent < 700) begin
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 25;
      endcase
      random_cfg();
      nframes = $urandom_range(1, 2);
      for (int f = 0; f < nframes; f++) begin
        tex = texture_e'($urandom_range(TEX_NOISE, TEX_SPIKES));
        cut = ($urandom_range(0, 4) == 0) ?
              $urandom_range(0, sb.eff_w() * sb.eff_h() - 1) : -1;
        run_frame(tex, cut);
      end
      settle();
    end

    // widest lines, clamped, resized once the first line has wrapped
    idle_pct = 0;
    write_cfg(11'd2047, 16'd3);
    run_frame(TEX_BINARY, 1030);
    settle();

    // largest height register, resized early in the frame
    write_cfg(11'd3, 16'hFFFF);
    run_frame(TEX_NOISE, 12);
    settle();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("laplacian_zero_crossing_edge verification clean");
    end else begin
      $display("laplacian_zero_crossing_edge verification failed");
    end
    $finish;
  end

endmodule
